FILE: src/hfve_pkg.sv
`default_nettype none

package hfve_pkg;

  localparam int KEY_MAX    = 16;
  localparam int WIN_DEPTH  = KEY_MAX - 1;
  localparam int KLEN_W     = $clog2(KEY_MAX + 1);
  localparam int KEY_REG_BYTES = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_COPY   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_KEY_LEN  = 2'd2;
  localparam logic [1:0] CFG_CAPACITY = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [4:0] KEY_LEN_RESET  = 5'd1;
  localparam logic [7:0] CAPACITY_RESET = 8'd50;

  localparam logic [67:0] LIM_POS = 68'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [67:0] LIM_NEG = 68'h0_8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] acc;
    logic        neg;
    logic        stop;
    logic        ovf;
    logic        sign_seen;
    logic        digit_seen;
  } parse_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  value_byte;
    logic        found;
    logic [63:0] number;
    logic        overflow;
    logic        end_of_run;
  } result_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CASE_BIT) : c;
  endfunction

  function automatic logic [7:0] key_byte(input logic [127:0] key, input int j);
    if (j < KEY_REG_BYTES) begin
      key_byte = key[j*8 +: 8];
    end else begin
      key_byte = CH_NUL;
    end
  endfunction

  function automatic parse_t parse_byte(input parse_t p, input logic [7:0] c);
    parse_t      q;
    logic        digit;
    logic [67:0] t;
    logic [67:0] lim;
    q     = p;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    t     = ({4'b0, p.acc} << 3) + ({4'b0, p.acc} << 1) + {60'b0, c - CH_ZERO};
    lim   = p.neg ? LIM_NEG : LIM_POS;
    if (!p.stop) begin
      if (!p.sign_seen && !p.digit_seen &&
          (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)) begin
        q = p;
      end else if (!p.sign_seen && !p.digit_seen &&
                   (c == CH_PLUS || c == CH_MINUS)) begin
        q.sign_seen = 1'b1;
        q.neg       = (c == CH_MINUS);
      end else if (!digit) begin
        q.stop = 1'b1;
      end else begin
        q.digit_seen = 1'b1;
        if (!p.ovf) begin
          if (t > lim) begin
            q.ovf = 1'b1;
          end else begin
            q.acc = t[63:0];
          end
        end
      end
    end
    parse_byte = q;
  endfunction

endpackage

`default_nettype wire

FILE: src/header_field_value_extractor_core.sv
`default_nettype none

// Header field value extractor.
// The input channel takes one header byte per transfer with a last flag; a zero
// byte or a byte with last set ends the buffer. The block looks for the
// configured key, skips the key and any blanks after it, and returns each value
// byte as a result transfer, followed by one summary transfer per buffer that
// carries the found flag, the value read as a signed decimal number and an
// overflow flag. end_of_run marks the last result caused by an input transfer.
// The input side accepts one byte per cycle while in_stall is low. All work on a
// byte is done in the cycle it is accepted, and its results are registered in
// the result queue that drives the output. Results pass through a four-entry
// queue; a byte that causes two results takes two entries, and the input stalls
// while fewer than two queue entries are free. When the receiver stalls, the
// head result holds and the queue fills until the input stalls.
// Configuration writes are taken in every cycle and should be made only while
// no buffer is in progress. Reset clears the queue and the buffer state and
// loads the register reset values: key length one, value capacity fifty.
module header_field_value_extractor_core
  import hfve_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire [7:0]          in_data_byte,
  input  wire                in_last,
  output logic               out_valid,
  input  wire                out_stall,
  output logic               out_kind,
  output logic [7:0]         out_value_byte,
  output logic               out_found,
  output logic signed [63:0] out_number,
  output logic               out_overflow,
  output logic               out_end_of_run,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [1:0]          cfg_index,
  input  wire [63:0]         cfg_data
);

  logic [63:0]       key_low_r;
  logic [63:0]       key_high_r;
  logic [4:0]        key_len_r;
  logic [7:0]        capacity_r;

  logic [7:0]        recent_r [WIN_DEPTH];
  logic [7:0]        recent_nxt [WIN_DEPTH];
  logic [1:0]        phase_r, phase_nxt;
  logic [7:0]        copied_r, copied_nxt;
  logic [KLEN_W-1:0] skip_r, skip_nxt;
  parse_t            parse_r, parse_nxt;

  result_t           fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  logic [127:0]      key;
  logic [KLEN_W-1:0] klen;
  logic [KLEN_W-1:0] mlen;
  logic              mlen_stop;
  logic [7:0]        win [KEY_MAX];
  logic              hit [KEY_MAX + 1];
  logic              key_hit;

  logic              in_xfer;
  logic              out_xfer;
  logic              byte_emit;
  logic              sum_emit;
  logic              sum_found;
  logic              clear;
  parse_t            par;
  result_t           byte_res;
  result_t           sum_res;
  result_t           ent0, ent1;
  logic              push0, push1;
  logic [1:0]        n_push;

  function automatic logic cap_hit(input logic [7:0] cnt, input logic [7:0] cap);
    cap_hit = (cap != 8'd0) && (cnt >= cap - 8'd1);
  endfunction

  assign cfg_ready = 1'b1;
  assign key       = {key_high_r, key_low_r};
  assign in_stall  = (count_r > CNT_W'(FIFO_DEPTH - 2));
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_xfer  = out_valid && !out_stall;

  always_comb begin
    if (key_len_r == 5'd0) begin
      klen = KLEN_W'(1);
    end else if (int'(key_len_r) > KEY_MAX) begin
      klen = KLEN_W'(KEY_MAX);
    end else begin
      klen = KLEN_W'(key_len_r);
    end
    mlen      = klen;
    mlen_stop = 1'b0;
    for (int j = 0; j < KEY_MAX; j++) begin
      if (!mlen_stop && (j >= int'(klen) || key_byte(key, j) == CH_NUL)) begin
        mlen      = KLEN_W'(j);
        mlen_stop = 1'b1;
      end
    end
  end

  always_comb begin
    win[0] = in_data_byte;
    for (int i = 1; i < KEY_MAX; i++) begin
      win[i] = recent_r[i-1];
    end
    hit[0] = 1'b0;
    for (int m = 1; m <= KEY_MAX; m++) begin
      hit[m] = 1'b1;
      for (int j = 0; j < m; j++) begin
        if (j == 0) begin
          if (win[m-1] != key_byte(key, 0)) hit[m] = 1'b0;
        end else begin
          if (fold(win[m-1-j]) != fold(key_byte(key, j))) hit[m] = 1'b0;
        end
      end
    end
    key_hit = (mlen != '0) && hit[mlen];
  end

  always_comb begin
    recent_nxt = recent_r;
    phase_nxt  = phase_r;
    copied_nxt = copied_r;
    skip_nxt   = skip_r;
    par        = parse_r;
    byte_emit  = 1'b0;
    sum_emit   = 1'b0;
    sum_found  = 1'b0;
    clear      = 1'b0;
    if (in_xfer) begin
      if (in_data_byte == CH_NUL) begin
        sum_emit  = (phase_r != PH_DONE);
        sum_found = (phase_r == PH_COPY);
        clear     = 1'b1;
      end else begin
        case (phase_r)
          PH_SEARCH: begin
            if (key_hit) begin
              phase_nxt = PH_SKIP;
              skip_nxt  = klen - mlen;
            end
            recent_nxt[0] = in_data_byte;
            for (int i = 1; i < WIN_DEPTH; i++) begin
              recent_nxt[i] = recent_r[i-1];
            end
          end
          PH_SKIP: begin
            if (skip_r != '0) begin
              skip_nxt = skip_r - KLEN_W'(1);
            end else if (in_data_byte == CH_SPACE || in_data_byte == CH_TAB) begin
              phase_nxt = PH_SKIP;
            end else if (in_data_byte == CH_CR || in_data_byte == CH_LF ||
                         capacity_r <= 8'd1) begin
              sum_emit  = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              byte_emit  = 1'b1;
              par        = parse_byte(parse_r, in_data_byte);
              copied_nxt = 8'd1;
              phase_nxt  = PH_COPY;
              if (cap_hit(8'd1, capacity_r)) begin
                sum_emit  = 1'b1;
                sum_found = 1'b1;
                phase_nxt = PH_DONE;
              end
            end
          end
          PH_COPY: begin
            if (in_data_byte == CH_CR || in_data_byte == CH_LF) begin
              sum_emit  = 1'b1;
              sum_found = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              byte_emit  = 1'b1;
              par        = parse_byte(parse_r, in_data_byte);
              copied_nxt = copied_r + 8'd1;
              if (cap_hit(copied_nxt, capacity_r)) begin
                sum_emit  = 1'b1;
                sum_found = 1'b1;
                phase_nxt = PH_DONE;
              end
            end
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
        if (in_last) begin
          if (phase_nxt != PH_DONE) begin
            sum_emit  = 1'b1;
            sum_found = (phase_nxt == PH_COPY);
          end
          clear = 1'b1;
        end
      end
    end
    parse_nxt = par;
    if (clear) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        recent_nxt[i] = CH_NUL;
      end
      phase_nxt  = PH_SEARCH;
      copied_nxt = 8'd0;
      skip_nxt   = '0;
      parse_nxt  = '0;
    end
  end

  always_comb begin
    byte_res            = '0;
    byte_res.value_byte = in_data_byte;
    byte_res.end_of_run = !sum_emit;
    sum_res             = '0;
    sum_res.kind        = 1'b1;
    sum_res.end_of_run  = 1'b1;
    sum_res.found       = sum_found;
    if (!sum_found) begin
      sum_res.number = '1;
    end else if (par.ovf) begin
      sum_res.number   = '1;
      sum_res.overflow = 1'b1;
    end else begin
      sum_res.number = par.neg ? (64'd0 - par.acc) : par.acc;
    end
    ent0   = byte_emit ? byte_res : sum_res;
    ent1   = sum_res;
    push0  = byte_emit || sum_emit;
    push1  = byte_emit && sum_emit;
    n_push = {1'b0, push0} + {1'b0, push1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= KEY_LEN_RESET;
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        CFG_KEY_LEN:  key_len_r  <= cfg_data[4:0];
        CFG_CAPACITY: capacity_r <= cfg_data[7:0];
        default:      key_low_r  <= key_low_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        recent_r[i] <= CH_NUL;
      end
      phase_r  <= PH_SEARCH;
      copied_r <= 8'd0;
      skip_r   <= '0;
      parse_r  <= '0;
    end else begin
      recent_r <= recent_nxt;
      phase_r  <= phase_nxt;
      copied_r <= copied_nxt;
      skip_r   <= skip_nxt;
      parse_r  <= parse_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_push);
      rd_ptr_r <= rd_ptr_r + PTR_W'(out_xfer);
      count_r  <= count_r + CNT_W'(n_push) - CNT_W'(out_xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      fifo_r[wr_ptr_r] <= ent0;
    end
    if (push1) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= ent1;
    end
  end

  always_comb begin
    out_kind       = fifo_r[rd_ptr_r].kind;
    out_value_byte = fifo_r[rd_ptr_r].value_byte;
    out_found      = fifo_r[rd_ptr_r].found;
    out_number     = signed'(fifo_r[rd_ptr_r].number);
    out_overflow   = fifo_r[rd_ptr_r].overflow;
    out_end_of_run = fifo_r[rd_ptr_r].end_of_run;
  end

endmodule

`default_nettype wire
